[hw/rtl/mmwf_pkg.sv]
`timescale 1ns / 1ps

package mmwf_pkg;

	// Pixel and window-row widths
	localparam int PIX_W = 8;
	localparam int ROW_W = 12;

	// Output queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	// Configuration register indexes
	localparam logic [2:0] REG_KERNEL   = 3'd0;
	localparam logic [2:0] REG_TAKE_MAX = 3'd1;
	localparam logic [2:0] REG_WIDTH    = 3'd2;
	localparam logic [2:0] REG_HEIGHT   = 3'd3;

	typedef logic [PIX_W-1:0] pix_t;

	// One column extreme as it travels along the chain
	typedef struct packed {
		logic             valid;
		logic [ROW_W-1:0] row;
		pix_t             value;
	} col_t;

	// One result item
	typedef struct packed {
		pix_t pixel;
		logic last;
	} res_t;

	function automatic pix_t pick(pix_t a, pix_t b, logic take_max);
		if (take_max) return (a > b) ? a : b;
		return (a < b) ? a : b;
	endfunction

	// Neutral value: never wins against a real pixel
	function automatic pix_t ident(logic take_max);
		return take_max ? '0 : '1;
	endfunction

endpackage

[hw/rtl/mmwf_line_bank.sv]
`timescale 1ns / 1ps

module mmwf_line_bank #(
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  mmwf_pkg::pix_t   wdata,
	input  logic [AW-1:0]    raddr,
	output mmwf_pkg::pix_t   rdata
);
	import mmwf_pkg::*;

	pix_t mem [DEPTH];

	// One row of the line store, registered read
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

[hw/rtl/mmwf_cell.sv]
`timescale 1ns / 1ps

module mmwf_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         shift,
	input  mmwf_pkg::col_t               din,
	output mmwf_pkg::col_t               dout,
	input  logic                         use_age,
	input  logic [mmwf_pkg::ROW_W-1:0]   ref_row,
	input  logic                         take_max,
	output mmwf_pkg::pix_t               contrib
);
	import mmwf_pkg::*;

	logic             valid_q;
	logic [ROW_W-1:0] row_q;
	pix_t             value_q;

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= din.valid;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (shift) begin
			row_q   <= din.row;
			value_q <= din.value;
		end
	end

	assign dout = '{valid: valid_q, row: row_q, value: value_q};

	// Take part only for a column of the same centre row inside the span
	assign contrib = (use_age && valid_q && (row_q == ref_row)) ? value_q : ident(take_max);

endmodule

[hw/rtl/mmwf_reduce.sv]
`timescale 1ns / 1ps

module mmwf_reduce #(
	parameter int N = 15
) (
	input  logic           take_max,
	input  mmwf_pkg::pix_t din [N],
	output mmwf_pkg::pix_t dout
);
	import mmwf_pkg::*;

	localparam int P = 2 ** $clog2(N);

	pix_t tree [2*P-1];

	// Balanced min/max tree, leaves padded with the neutral value
	always_comb begin
		for (int i = 0; i < P; i++) begin
			if (i < N) tree[P-1+i] = din[i];
			else       tree[P-1+i] = ident(take_max);
		end
		for (int i = P - 2; i >= 0; i--) begin
			tree[i] = pick(tree[2*i+1], tree[2*i+2], take_max);
		end
	end

	assign dout = tree[0];

endmodule

[hw/rtl/mmwf_out_fifo.sv]
`timescale 1ns / 1ps

module mmwf_out_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  mmwf_pkg::res_t                push_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output mmwf_pkg::res_t                out_data,
	output logic [mmwf_pkg::FIFO_CW-1:0]  count
);
	import mmwf_pkg::*;

	res_t               data_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q;
	logic [FIFO_AW-1:0] rd_q;
	logic [FIFO_CW-1:0] count_q;
	logic               pop;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	assign out_data  = data_q[rd_q];
	assign count     = count_q;

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + FIFO_AW'(1);
			if (pop)  rd_q <= rd_q + FIFO_AW'(1);
			if (push && !pop)      count_q <= count_q + FIFO_CW'(1);
			else if (pop && !push) count_q <= count_q - FIFO_CW'(1);
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) data_q[wr_q] <= push_data;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < FIFO_CW'(FIFO_DEPTH)))
		else $error("output queue overrun");

endmodule

[hw/rtl/grayscale_min_max_window_filter.sv]
`timescale 1ns / 1ps
// Result path: stage 1 registers, column chain (stage 2), then the output queue.
// Throughput: one item per cycle while the output queue has room, set by the
// line store banks and the column chain that shifts once per item; in_ready
// drops after a configuration write while the frame geometry settles, and
// after the last pixel of a frame whose window reach exceeds the frame, while
// the chain is run on to the first result.
// Reset: counters, chain valid flags and configuration registers cleared to
// defaults; line store contents are left as they are.
module grayscale_min_max_window_filter #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_KERNEL = 15
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [2:0]            cfg_index,
	input  logic [10:0]           cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  mode,
	input  mmwf_pkg::pix_t        pixel_in,
	output logic                  out_valid,
	input  logic                  out_ready,
	output mmwf_pkg::pix_t        pixel_out,
	output logic                  frame_last
);
	import mmwf_pkg::*;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int WID_W  = $clog2(MAX_WIDTH + 1);
	localparam int HALF_W = $clog2(MAX_KERNEL / 2 + 1);
	localparam int BANK_W = $clog2(MAX_KERNEL);
	localparam int CNT_W  = WID_W + 12;

	// Configuration registers
	logic [3:0]  ks_q;
	logic        take_max_q;
	logic [10:0] width_q;
	logic [10:0] height_q;
	logic [1:0]  hold_q;
	logic        cfg_wr;
	logic        cfg_clr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	// Only a write to an existing register restarts the frame
	assign cfg_clr   = cfg_wr &&
		(cfg_index inside {REG_KERNEL, REG_TAKE_MAX, REG_WIDTH, REG_HEIGHT});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ks_q       <= 4'd3;
			take_max_q <= 1'b1;
			width_q    <= 11'd640;
			height_q   <= 11'd480;
			hold_q     <= '0;
		end else begin
			if (cfg_wr) begin
				hold_q <= 2'd3;
				case (cfg_index)
					REG_KERNEL:   ks_q       <= cfg_data[3:0];
					REG_TAKE_MAX: take_max_q <= cfg_data[0];
					REG_WIDTH:    width_q    <= cfg_data;
					REG_HEIGHT:   height_q   <= cfg_data;
					default: ;
				endcase
			end else if (hold_q != '0) begin
				hold_q <= hold_q - 2'd1;
			end
		end
	end

	// Frame geometry, settled over two register stages
	logic [WID_W-1:0]  w_eff_q;
	logic [10:0]       h_eff_q;
	logic [HALF_W-1:0] half_q;
	logic [HALF_W:0]   span_q;
	logic [CNT_W-1:0]  total_q;
	logic [CNT_W-1:0]  total_m1_q;
	logic [CNT_W-1:0]  lag_q;

	always_ff @(posedge clk) begin
		if (width_q == '0)                 w_eff_q <= WID_W'(1);
		else if (int'(width_q) > MAX_WIDTH) w_eff_q <= WID_W'(MAX_WIDTH);
		else                                w_eff_q <= WID_W'(width_q);
		h_eff_q <= (height_q == '0) ? 11'd1 : height_q;
		if (!ks_q[0])                              half_q <= '0;
		else if (int'(ks_q >> 1) > MAX_KERNEL / 2) half_q <= HALF_W'(MAX_KERNEL / 2);
		else                                       half_q <= HALF_W'(ks_q >> 1);
		span_q     <= {half_q, 1'b0};
		total_q    <= CNT_W'(w_eff_q) * CNT_W'(h_eff_q);
		total_m1_q <= CNT_W'(w_eff_q) * CNT_W'(h_eff_q) - CNT_W'(1);
		lag_q      <= CNT_W'(half_q) * CNT_W'(w_eff_q) + CNT_W'(half_q);
	end

	// Position tracking
	logic [CNT_W-1:0]  rx_q;
	logic [CNT_W-1:0]  ev_q;
	logic [CNT_W-1:0]  oidx_q;
	logic [ROW_W-1:0]  vrow_q;
	logic [COL_W-1:0]  vcol_q;
	logic [BANK_W-1:0] bank_q;

	logic accept, is_pix, is_drain, event_s0, emit_s0, last_s0, col_wrap, fill_s0;
	logic [FIFO_CW-1:0] fifo_count;
	logic emit_s1, emit_s2;

	// All pixels in but the window reach lies past the frame: step the chain on its own
	assign fill_s0  = (hold_q == '0) && (rx_q == total_q) && (ev_q < lag_q) &&
		(oidx_q < total_q);
	assign in_ready = (hold_q == '0) && !fill_s0 &&
		((int'(fifo_count) + int'(emit_s1) + int'(emit_s2)) < FIFO_DEPTH);
	assign accept   = in_valid && in_ready;
	assign is_pix   = !mode && (rx_q < total_q);
	assign is_drain = mode && (rx_q == total_q) && (oidx_q < total_q);
	assign event_s0 = (accept && (is_pix || is_drain)) || fill_s0;
	assign emit_s0  = event_s0 && (ev_q >= lag_q);
	assign last_s0  = emit_s0 && (oidx_q == total_m1_q);
	assign col_wrap = ((WID_W'(vcol_q) + WID_W'(1)) == w_eff_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_q   <= '0;
			ev_q   <= '0;
			oidx_q <= '0;
			vrow_q <= '0;
			vcol_q <= '0;
			bank_q <= '0;
		end else if (cfg_clr || last_s0) begin
			rx_q   <= '0;
			ev_q   <= '0;
			oidx_q <= '0;
			vrow_q <= '0;
			vcol_q <= '0;
			bank_q <= '0;
		end else if (event_s0) begin
			ev_q <= ev_q + CNT_W'(1);
			if (is_pix)  rx_q   <= rx_q + CNT_W'(1);
			if (emit_s0) oidx_q <= oidx_q + CNT_W'(1);
			if (col_wrap) begin
				vcol_q <= '0;
				vrow_q <= vrow_q + ROW_W'(1);
				bank_q <= (int'(bank_q) == MAX_KERNEL - 1) ? '0 : bank_q + BANK_W'(1);
			end else begin
				vcol_q <= vcol_q + COL_W'(1);
			end
		end
	end

	// Line store: one bank per row, rows placed round robin
	pix_t rdata [MAX_KERNEL];

	for (genvar b = 0; b < MAX_KERNEL; b++) begin : g_bank
		mmwf_line_bank #(.DEPTH(MAX_WIDTH)) u_bank (
			.clk  (clk),
			.we   (event_s0 && is_pix && (bank_q == BANK_W'(b))),
			.waddr(vcol_q),
			.wdata(pixel_in),
			.raddr(vcol_q),
			.rdata(rdata[b])
		);
	end

	// Rows of each bank that fall inside the clipped window
	logic inc_d [MAX_KERNEL];

	always_comb begin
		int dd;
		for (int b = 0; b < MAX_KERNEL; b++) begin
			dd = (int'(bank_q) >= b) ? int'(bank_q) - b : int'(bank_q) + MAX_KERNEL - b;
			inc_d[b] = (dd <= int'(span_q)) && (dd <= int'(vrow_q)) &&
				((int'(vrow_q) - dd) < int'(h_eff_q));
		end
	end

	// Stage 1 registers
	logic              v_s1, last_s1, crv_s1;
	logic              inc_s1 [MAX_KERNEL];
	logic [BANK_W-1:0] byp_s1;
	pix_t              pix_s1;
	logic [ROW_W-1:0]  cr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			emit_s1 <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			v_s1    <= event_s0;
			emit_s1 <= emit_s0;
			last_s1 <= last_s0;
		end
	end

	always_ff @(posedge clk) begin
		inc_s1 <= inc_d;
		byp_s1 <= bank_q;
		pix_s1 <= pixel_in;
		cr_s1  <= vrow_q - ROW_W'(half_q);
		crv_s1 <= (vrow_q >= ROW_W'(half_q)) &&
			((vrow_q - ROW_W'(half_q)) < ROW_W'(h_eff_q));
	end

	// Column extreme; the newest row comes straight from the item
	pix_t vert_in [MAX_KERNEL];
	pix_t col_val;

	always_comb begin
		for (int b = 0; b < MAX_KERNEL; b++) begin
			if (!inc_s1[b])                  vert_in[b] = ident(take_max_q);
			else if (byp_s1 == BANK_W'(b))   vert_in[b] = pix_s1;
			else                             vert_in[b] = rdata[b];
		end
	end

	mmwf_reduce #(.N(MAX_KERNEL)) u_vert (
		.take_max(take_max_q),
		.din     (vert_in),
		.dout    (col_val)
	);

	// Chain of column cells, cell a holds the entry of age a
	col_t             chain [MAX_KERNEL];
	col_t             head;
	pix_t             contrib [MAX_KERNEL];
	logic [ROW_W-1:0] ref_row;
	pix_t             out_val;

	assign head    = '{valid: crv_s1, row: cr_s1, value: col_val};
	assign ref_row = chain[BANK_W'(half_q)].row;

	for (genvar a = 0; a < MAX_KERNEL; a++) begin : g_cell
		mmwf_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift   (v_s1),
			.din     ((a == 0) ? head : chain[(a == 0) ? 0 : a - 1]),
			.dout    (chain[a]),
			.use_age (a <= int'(span_q)),
			.ref_row (ref_row),
			.take_max(take_max_q),
			.contrib (contrib[a])
		);
	end

	// Stage 2: horizontal extreme over the chain
	logic last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s2 <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			emit_s2 <= v_s1 && emit_s1;
			last_s2 <= last_s1;
		end
	end

	mmwf_reduce #(.N(MAX_KERNEL)) u_horiz (
		.take_max(take_max_q),
		.din     (contrib),
		.dout    (out_val)
	);

	// Output queue
	res_t out_data;
	res_t push_data;

	assign push_data = '{pixel: out_val, last: last_s2};

	mmwf_out_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (emit_s2),
		.push_data(push_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.count    (fifo_count)
	);

	assign pixel_out  = out_data.pixel;
	assign frame_last = out_data.last;

	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> !in_ready)
		else $error("item taken while geometry settles");

	assert property (@(posedge clk) disable iff (!arst_n)
		emit_s2 |-> chain[BANK_W'(half_q)].valid)
		else $error("centre column of the window not valid");

	assert property (@(posedge clk) disable iff (!arst_n)
		oidx_q <= rx_q)
		else $error("more results than pixels");

	assert property (@(posedge clk) disable iff (!arst_n)
		emit_s0 |-> (ev_q >= lag_q) && (oidx_q < total_q))
		else $error("result beyond frame end");

endmodule
